[rtl/tsssa_pkg.sv]
package tsssa_pkg;

    localparam int CNT_OUT_W  = 20;
    localparam int PROP_OUT_W = 39;
    localparam int PROP_W     = 40;
    localparam int CFG_W      = 20;
    localparam int DRAW_W     = 39;

    // Configuration register indexes.
    localparam logic [1:0] CFG_START_A = 2'd0;
    localparam logic [1:0] CFG_START_L = 2'd1;
    localparam logic [1:0] CFG_START_D = 2'd2;

    // Command codes.
    localparam logic CMD_STEP    = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    // Reaction codes reported in the fired field.
    localparam logic [1:0] FIRE_NONE = 2'd0;
    localparam logic [1:0] FIRE_AD   = 2'd1;
    localparam logic [1:0] FIRE_AL   = 2'd2;
    localparam logic [1:0] FIRE_LD   = 2'd3;

    typedef struct packed {
        logic              cmd;
        logic [DRAW_W-1:0] rand_draw;
    } step_item_t;

    typedef struct packed {
        logic [CNT_OUT_W-1:0]  count_a;
        logic [CNT_OUT_W-1:0]  count_l;
        logic [CNT_OUT_W-1:0]  count_d;
        logic [1:0]            fired;
        logic [PROP_OUT_W-1:0] prop_ad;
        logic [PROP_OUT_W-1:0] prop_al;
        logic [PROP_OUT_W-1:0] prop_ld;
        logic [PROP_OUT_W-1:0] prop_aa;
        logic [PROP_OUT_W-1:0] prop_dd;
        logic [PROP_OUT_W-1:0] prop_ll;
    } result_item_t;

    // The six pair propensities, each kept modulo 2^40.
    typedef struct packed {
        logic [PROP_W-1:0] ad;
        logic [PROP_W-1:0] al;
        logic [PROP_W-1:0] ld;
        logic [PROP_W-1:0] aa;
        logic [PROP_W-1:0] dd;
        logic [PROP_W-1:0] ll;
    } prop_set_t;

endpackage

[rtl/three_species_ssa_step_core.sv]
// Three-species reaction stepper with direct-method reaction selection.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the
// start counts of A, L and D. cfg_ready is always high; for the cycle after a
// configuration transfer step_ready is held low while the restart products of
// the new start counts are registered.
// Step channel (step_valid/step_ready, step_item) takes one command per
// transfer: a restart loads the start counts, a step draws one reaction.
// Each command produces exactly one result on the result channel
// (result_valid/result_ready, result_item). Throughput is one command per cycle
// while the skid is empty and no configuration write is pending: the selection
// sums, compares and the incremental propensity updates all fit between the
// state registers and the result register. Restart products come from six
// multipliers on the start registers, precomputed in their own register stage.
// When the receiver stalls, the result register holds and one more result
// goes into a skid register; step_ready then drops until the skid drains.
// Reset clears the start registers, the counts and all propensities, and
// leaves both output registers empty.
module three_species_ssa_step_core
    import tsssa_pkg::*;
#(
    parameter int COUNT_WIDTH = 20
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             step_valid,
    output logic             step_ready,
    input  step_item_t       step_item,
    output logic             result_valid,
    input  logic             result_ready,
    output result_item_t     result_item
);

    logic [CFG_W-1:0]       start_a_reg;
    logic [CFG_W-1:0]       start_l_reg;
    logic [CFG_W-1:0]       start_d_reg;
    logic [COUNT_WIDTH-1:0] start_a_cut;
    logic [COUNT_WIDTH-1:0] start_l_cut;
    logic [COUNT_WIDTH-1:0] start_d_cut;
    logic                   pend_reg;

    logic [COUNT_WIDTH-1:0] cnt_a_reg;
    logic [COUNT_WIDTH-1:0] cnt_l_reg;
    logic [COUNT_WIDTH-1:0] cnt_d_reg;
    prop_set_t              prop_reg;
    logic [COUNT_WIDTH-1:0] cnt_a_next;
    logic [COUNT_WIDTH-1:0] cnt_l_next;
    logic [COUNT_WIDTH-1:0] cnt_d_next;
    prop_set_t              prop_next;
    logic [1:0]             fired_next;

    prop_set_t              init_prop;
    logic [COUNT_WIDTH-1:0] step_a;
    logic [COUNT_WIDTH-1:0] step_l;
    logic [COUNT_WIDTH-1:0] step_d;
    prop_set_t              step_prop;
    logic [1:0]             step_fired;

    result_item_t           res_next;
    result_item_t           out_reg;
    result_item_t           skid_reg;
    logic                   out_valid_reg;
    logic                   skid_valid_reg;
    logic                   step_xfer;
    logic                   out_free;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_a_reg <= '0;
            start_l_reg <= '0;
            start_d_reg <= '0;
            pend_reg    <= 1'b0;
        end
        else
        begin
            pend_reg <= cfg_valid;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_START_A: start_a_reg <= cfg_data;
                    CFG_START_L: start_l_reg <= cfg_data;
                    CFG_START_D: start_d_reg <= cfg_data;
                    default:     ;
                endcase
            end
        end
    end

    assign start_a_cut = COUNT_WIDTH'(start_a_reg);
    assign start_l_cut = COUNT_WIDTH'(start_l_reg);
    assign start_d_cut = COUNT_WIDTH'(start_d_reg);

    tsssa_restart_prod #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_restart_prod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start_a (start_a_cut),
        .start_l (start_l_cut),
        .start_d (start_d_cut),
        .prod    (init_prop)
    );

    tsssa_step_calc #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step_calc (
        .cnt_a     (cnt_a_reg),
        .cnt_l     (cnt_l_reg),
        .cnt_d     (cnt_d_reg),
        .prop      (prop_reg),
        .rand_draw (step_item.rand_draw),
        .new_a     (step_a),
        .new_l     (step_l),
        .new_d     (step_d),
        .new_prop  (step_prop),
        .fired     (step_fired)
    );

    assign step_ready = !skid_valid_reg && !pend_reg;
    assign step_xfer  = step_valid && step_ready;
    assign out_free   = !out_valid_reg || result_ready;

    always_comb
    begin
        unique case (step_item.cmd)
            CMD_RESTART:
            begin
                cnt_a_next = start_a_cut;
                cnt_l_next = start_l_cut;
                cnt_d_next = start_d_cut;
                prop_next  = init_prop;
                fired_next = FIRE_NONE;
            end
            default:
            begin
                cnt_a_next = step_a;
                cnt_l_next = step_l;
                cnt_d_next = step_d;
                prop_next  = step_prop;
                fired_next = step_fired;
            end
        endcase
    end

    always_comb
    begin
        res_next.count_a = CNT_OUT_W'(cnt_a_next);
        res_next.count_l = CNT_OUT_W'(cnt_l_next);
        res_next.count_d = CNT_OUT_W'(cnt_d_next);
        res_next.fired   = fired_next;
        res_next.prop_ad = prop_next.ad[PROP_OUT_W-1:0];
        res_next.prop_al = prop_next.al[PROP_OUT_W-1:0];
        res_next.prop_ld = prop_next.ld[PROP_OUT_W-1:0];
        res_next.prop_aa = prop_next.aa[PROP_OUT_W-1:0];
        res_next.prop_dd = prop_next.dd[PROP_OUT_W-1:0];
        res_next.prop_ll = prop_next.ll[PROP_OUT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_a_reg <= '0;
            cnt_l_reg <= '0;
            cnt_d_reg <= '0;
            prop_reg  <= '0;
        end
        else if (step_xfer)
        begin
            cnt_a_reg <= cnt_a_next;
            cnt_l_reg <= cnt_l_next;
            cnt_d_reg <= cnt_d_next;
            prop_reg  <= prop_next;
        end
    end

    // Output register with one skid entry behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_free)
            begin
                out_valid_reg <= skid_valid_reg || step_xfer;
            end
            if (out_free)
            begin
                skid_valid_reg <= 1'b0;
            end
            else if (step_xfer)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (step_xfer)
            begin
                out_reg <= res_next;
            end
        end
        if (!out_free && step_xfer)
        begin
            skid_reg <= res_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_item  = out_reg;

endmodule

[rtl/tsssa_restart_prod.sv]
module tsssa_restart_prod
    import tsssa_pkg::*;
#(
    parameter int COUNT_WIDTH = 20
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [COUNT_WIDTH-1:0] start_a,
    input  logic [COUNT_WIDTH-1:0] start_l,
    input  logic [COUNT_WIDTH-1:0] start_d,
    output prop_set_t              prod
);

    // Wide enough for a full product and for n(n-1) before the halving.
    localparam int MW = (2 * COUNT_WIDTH > PROP_W + 1) ? 2 * COUNT_WIDTH : PROP_W + 1;

    logic [MW-1:0] a_ext;
    logic [MW-1:0] l_ext;
    logic [MW-1:0] d_ext;
    logic [MW-1:0] ad_full;
    logic [MW-1:0] al_full;
    logic [MW-1:0] ld_full;
    logic [MW-1:0] aa_full;
    logic [MW-1:0] dd_full;
    logic [MW-1:0] ll_full;
    prop_set_t     prod_next;
    prop_set_t     prod_reg;

    assign a_ext = MW'(start_a);
    assign l_ext = MW'(start_l);
    assign d_ext = MW'(start_d);

    assign ad_full = a_ext * d_ext;
    assign al_full = a_ext * l_ext;
    assign ld_full = l_ext * d_ext;
    // For n = 0 the wrapped n - 1 is multiplied by zero, which gives zero pairs.
    assign aa_full = a_ext * MW'(start_a - COUNT_WIDTH'(1));
    assign dd_full = d_ext * MW'(start_d - COUNT_WIDTH'(1));
    assign ll_full = l_ext * MW'(start_l - COUNT_WIDTH'(1));

    always_comb
    begin
        prod_next.ad = ad_full[PROP_W-1:0];
        prod_next.al = al_full[PROP_W-1:0];
        prod_next.ld = ld_full[PROP_W-1:0];
        prod_next.aa = aa_full[PROP_W:1];
        prod_next.dd = dd_full[PROP_W:1];
        prod_next.ll = ll_full[PROP_W:1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_reg <= '0;
        end
        else
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

[rtl/tsssa_step_calc.sv]
module tsssa_step_calc
    import tsssa_pkg::*;
#(
    parameter int COUNT_WIDTH = 20
)
(
    input  logic [COUNT_WIDTH-1:0] cnt_a,
    input  logic [COUNT_WIDTH-1:0] cnt_l,
    input  logic [COUNT_WIDTH-1:0] cnt_d,
    input  prop_set_t              prop,
    input  logic [DRAW_W-1:0]      rand_draw,
    output logic [COUNT_WIDTH-1:0] new_a,
    output logic [COUNT_WIDTH-1:0] new_l,
    output logic [COUNT_WIDTH-1:0] new_d,
    output prop_set_t              new_prop,
    output logic [1:0]             fired
);

    logic [PROP_W+1:0] s0;
    logic [PROP_W+1:0] s1;
    logic [PROP_W+1:0] s2;
    logic [PROP_W+1:0] draw_ext;
    logic [1:0]        pick;
    logic              a_zero;
    logic              l_zero;
    logic              d_zero;
    logic              l_full;
    logic              d_full;
    logic              a_near_full;
    logic [PROP_W-1:0] ax;
    logic [PROP_W-1:0] lx;
    logic [PROP_W-1:0] dx;

    assign s0       = (PROP_W + 2)'(prop.ad);
    assign s1       = s0 + (PROP_W + 2)'(prop.al);
    assign s2       = s1 + (PROP_W + 2)'(prop.ld);
    assign draw_ext = (PROP_W + 2)'(rand_draw);

    assign a_zero      = (cnt_a == '0);
    assign l_zero      = (cnt_l == '0);
    assign d_zero      = (cnt_d == '0);
    assign l_full      = &cnt_l;
    assign d_full      = &cnt_d;
    // A count of max-1 or max cannot take two more.
    assign a_near_full = &cnt_a[COUNT_WIDTH-1:1];

    assign ax = PROP_W'(cnt_a);
    assign lx = PROP_W'(cnt_l);
    assign dx = PROP_W'(cnt_d);

    always_comb
    begin
        priority if (draw_ext < s0)
        begin
            pick = FIRE_AD;
        end
        else if (draw_ext < s1)
        begin
            pick = FIRE_AL;
        end
        else if (draw_ext < s2)
        begin
            pick = FIRE_LD;
        end
        else
        begin
            pick = FIRE_NONE;
        end
    end

    // Propensities follow the count changes by their exact differences,
    // so no multiplier is needed on the step path.
    always_comb
    begin
        new_a    = cnt_a;
        new_l    = cnt_l;
        new_d    = cnt_d;
        new_prop = prop;
        fired    = FIRE_NONE;
        unique case (pick)
            FIRE_AD:
            begin
                if (!d_full && !a_zero)
                begin
                    fired       = FIRE_AD;
                    new_a       = cnt_a - COUNT_WIDTH'(1);
                    new_d       = cnt_d + COUNT_WIDTH'(1);
                    new_prop.ad = prop.ad + ax - dx - PROP_W'(1);
                    new_prop.al = prop.al - lx;
                    new_prop.ld = prop.ld + lx;
                    new_prop.aa = prop.aa - ax + PROP_W'(1);
                    new_prop.dd = prop.dd + dx;
                end
            end
            FIRE_AL:
            begin
                if (!l_full && !a_zero)
                begin
                    fired       = FIRE_AL;
                    new_a       = cnt_a - COUNT_WIDTH'(1);
                    new_l       = cnt_l + COUNT_WIDTH'(1);
                    new_prop.ad = prop.ad - dx;
                    new_prop.al = prop.al + ax - lx - PROP_W'(1);
                    new_prop.ld = prop.ld + dx;
                    new_prop.aa = prop.aa - ax + PROP_W'(1);
                    new_prop.ll = prop.ll + lx;
                end
            end
            FIRE_LD:
            begin
                if (!a_near_full && !l_zero && !d_zero)
                begin
                    fired       = FIRE_LD;
                    new_a       = cnt_a + COUNT_WIDTH'(2);
                    new_l       = cnt_l - COUNT_WIDTH'(1);
                    new_d       = cnt_d - COUNT_WIDTH'(1);
                    new_prop.ad = prop.ad - ax + (dx << 1) - PROP_W'(2);
                    new_prop.al = prop.al - ax + (lx << 1) - PROP_W'(2);
                    new_prop.ld = prop.ld - lx - dx + PROP_W'(1);
                    new_prop.aa = prop.aa + (ax << 1) + PROP_W'(1);
                    new_prop.dd = prop.dd - dx + PROP_W'(1);
                    new_prop.ll = prop.ll - lx + PROP_W'(1);
                end
            end
            default:
            begin
                fired = FIRE_NONE;
            end
        endcase
    end

endmodule

[rtl/tsssa_checker.sv]
module tsssa_checker
    import tsssa_pkg::*;
#(
    parameter int COUNT_WIDTH = 20
)
(
    input logic             clk,
    input logic             rst_n,
    input logic             cfg_valid,
    input logic             cfg_ready,
    input logic             step_ready,
    input logic             result_valid,
    input logic             result_ready,
    input result_item_t     result_item
);

    // Products can be rebuilt from the shown counts only when no count bit is cut off.
    localparam bit EXACT = (COUNT_WIDTH <= CNT_OUT_W);

    logic [PROP_W-1:0] ad_chk;
    logic [PROP_W-1:0] al_chk;
    logic [PROP_W-1:0] ld_chk;
    logic [PROP_W:0]   aa_chk;
    logic [PROP_W:0]   dd_chk;
    logic [PROP_W:0]   ll_chk;

    always_comb
    begin
        ad_chk = PROP_W'(result_item.count_a) * PROP_W'(result_item.count_d);
        al_chk = PROP_W'(result_item.count_a) * PROP_W'(result_item.count_l);
        ld_chk = PROP_W'(result_item.count_l) * PROP_W'(result_item.count_d);
        aa_chk = (PROP_W + 1)'(result_item.count_a)
                 * ((PROP_W + 1)'(result_item.count_a) - (PROP_W + 1)'(1));
        dd_chk = (PROP_W + 1)'(result_item.count_d)
                 * ((PROP_W + 1)'(result_item.count_d) - (PROP_W + 1)'(1));
        ll_chk = (PROP_W + 1)'(result_item.count_l)
                 * ((PROP_W + 1)'(result_item.count_l) - (PROP_W + 1)'(1));
    end

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_item))
        else $error("result changed or dropped while stalled");

    a_cross_props: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && EXACT |->
            result_item.prop_ad == ad_chk[PROP_OUT_W-1:0] &&
            result_item.prop_al == al_chk[PROP_OUT_W-1:0] &&
            result_item.prop_ld == ld_chk[PROP_OUT_W-1:0])
        else $error("cross propensity does not match the shown counts");

    a_self_props: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && EXACT |->
            result_item.prop_aa == aa_chk[PROP_OUT_W:1] &&
            result_item.prop_dd == dd_chk[PROP_OUT_W:1] &&
            result_item.prop_ll == ll_chk[PROP_OUT_W:1])
        else $error("pair propensity does not match the shown counts");

    a_cfg_blocks_step: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> !step_ready)
        else $error("step accepted before restart products were refreshed");

endmodule

bind three_species_ssa_step_core tsssa_checker #(
    .COUNT_WIDTH (COUNT_WIDTH)
) u_tsssa_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .step_ready   (step_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item)
);

[bench/three_species_ssa_step_core_tb.sv]
module three_species_ssa_step_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tsssa_pkg::*;

    localparam int CW = CNT_OUT_W;
    localparam logic [CW-1:0] COUNT_MAX = {CW{1'b1}};
    localparam logic [DRAW_W-1:0] DRAW_MAX = {DRAW_W{1'b1}};
    // Index 3 addresses no register; a write there must leave the start counts alone.
    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int IDLE_MAX = 16;
    localparam int MAX_REPORTS = 10;
    localparam int RANDOM_PHASES = 9;
    localparam int PHASE_ITEMS = 150;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic step_valid;
    logic step_ready;
    step_item_t step_item;
    logic result_valid;
    logic result_ready;
    result_item_t result_item;

    // Mirror of the block: start registers, species counts and propensities.
    logic [CW-1:0] start_a;
    logic [CW-1:0] start_l;
    logic [CW-1:0] start_d;
    logic [CW-1:0] cur_a;
    logic [CW-1:0] cur_l;
    logic [CW-1:0] cur_d;
    prop_set_t cur_props;

    result_item_t expected_results [$];

    int send_idle = IDLE_MAX;
    int sink_idle = IDLE_MAX;
    int failures = 0;
    int n_commands = 0;
    int n_restarts = 0;
    int n_checked = 0;
    int n_cfg_writes = 0;
    int fire_tally [4];

    three_species_ssa_step_core #(
        .COUNT_WIDTH(CW)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .step_valid(step_valid),
        .step_ready(step_ready),
        .step_item(step_item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result_item(result_item)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("three_species_ssa_step_core verification failed");
        $finish;
    end

    function automatic prop_set_t pair_products(input logic [CW-1:0] a, input logic [CW-1:0] l,
                                                input logic [CW-1:0] d);
        logic [63:0] wa;
        logic [63:0] wl;
        logic [63:0] wd;
        logic [63:0] t;
        prop_set_t p;
        wa = '0;
        wl = '0;
        wd = '0;
        wa[CW-1:0] = a;
        wl[CW-1:0] = l;
        wd[CW-1:0] = d;
        t = wa * wd;
        p.ad = t[PROP_W-1:0];
        t = wa * wl;
        p.al = t[PROP_W-1:0];
        t = wl * wd;
        p.ld = t[PROP_W-1:0];
        t = (wa == 64'd0) ? 64'd0 : (wa * (wa - 64'd1)) >> 1;
        p.aa = t[PROP_W-1:0];
        t = (wd == 64'd0) ? 64'd0 : (wd * (wd - 64'd1)) >> 1;
        p.dd = t[PROP_W-1:0];
        t = (wl == 64'd0) ? 64'd0 : (wl * (wl - 64'd1)) >> 1;
        p.ll = t[PROP_W-1:0];
        return p;
    endfunction

    // Running sum of the first k reactive propensities, formed without wrap.
    function automatic logic [PROP_W+1:0] cumulative(input int k);
        logic [PROP_W+1:0] s;
        s = {2'b00, cur_props.ad};
        if (k > 1)
            s = s + {2'b00, cur_props.al};
        if (k > 2)
            s = s + {2'b00, cur_props.ld};
        return s;
    endfunction

    // A draw just at or just below a cumulative boundary, clamped to the field.
    function automatic logic [DRAW_W-1:0] draw_at(input int k, input int below);
        logic [PROP_W+1:0] s;
        s = cumulative(k);
        if (below != 0 && s != '0)
            s = s - (PROP_W + 2)'(1);
        if (s > {3'b000, DRAW_MAX})
            return DRAW_MAX;
        return s[DRAW_W-1:0];
    endfunction

    function automatic logic [DRAW_W-1:0] random_draw();
        logic [63:0] t;
        t = {$urandom, $urandom};
        return t[DRAW_W-1:0];
    endfunction

    // Mostly draws that select a reaction, some on the boundaries, some anywhere.
    function automatic logic [DRAW_W-1:0] pick_draw();
        logic [PROP_W+1:0] reach;
        logic [63:0] t;
        int mode;
        reach = cumulative(3);
        if (reach > {3'b000, DRAW_MAX})
            reach = {3'b000, DRAW_MAX} + (PROP_W + 2)'(1);
        mode = $urandom_range(0, 99);
        if (mode < 12 || reach == '0)
            return random_draw();
        if (mode < 25)
            return draw_at($urandom_range(1, 3), $urandom_range(0, 1));
        t = {$urandom, $urandom};
        t = t % {22'd0, reach};
        return t[DRAW_W-1:0];
    endfunction

    function automatic logic [CW-1:0] pick_count();
        logic [CW-1:0] v;
        int bits;
        case ($urandom_range(0, 9))
            0: v = COUNT_MAX - CW'($urandom_range(0, 3));
            1: v = CW'($urandom_range(0, 3));
            default:
            begin
                bits = $urandom_range(1, CW);
                v = CW'($urandom) & (COUNT_MAX >> (CW - bits));
            end
        endcase
        return v;
    endfunction

    // Applies one command to the mirrored state and returns the result it must produce.
    function automatic result_item_t advance_system(input step_item_t it);
        logic [1:0] fire;
        logic [PROP_W+1:0] draw;
        logic [CW:0] a_plus2;
        result_item_t r;
        fire = FIRE_NONE;
        if (it.cmd == CMD_RESTART)
        begin
            cur_a = start_a;
            cur_l = start_l;
            cur_d = start_d;
            cur_props = pair_products(cur_a, cur_l, cur_d);
        end
        else
        begin
            draw = {3'b000, it.rand_draw};
            if (draw < cumulative(1))
                fire = FIRE_AD;
            else if (draw < cumulative(2))
                fire = FIRE_AL;
            else if (draw < cumulative(3))
                fire = FIRE_LD;
            a_plus2 = {1'b0, cur_a} + (CW + 1)'(2);
            // A reaction that would push a product past the counter width, or that lacks a reactant, becomes null.
            case (fire)
                FIRE_AD:
                begin
                    if (cur_d == COUNT_MAX || cur_a == '0)
                        fire = FIRE_NONE;
                    else
                    begin
                        cur_a = cur_a - CW'(1);
                        cur_d = cur_d + CW'(1);
                    end
                end
                FIRE_AL:
                begin
                    if (cur_l == COUNT_MAX || cur_a == '0)
                        fire = FIRE_NONE;
                    else
                    begin
                        cur_a = cur_a - CW'(1);
                        cur_l = cur_l + CW'(1);
                    end
                end
                FIRE_LD:
                begin
                    if (a_plus2 > {1'b0, COUNT_MAX} || cur_l == '0 || cur_d == '0)
                        fire = FIRE_NONE;
                    else
                    begin
                        cur_a = a_plus2[CW-1:0];
                        cur_l = cur_l - CW'(1);
                        cur_d = cur_d - CW'(1);
                    end
                end
                default: ;
            endcase
            if (fire != FIRE_NONE)
                cur_props = pair_products(cur_a, cur_l, cur_d);
        end
        r.count_a = cur_a;
        r.count_l = cur_l;
        r.count_d = cur_d;
        r.fired = fire;
        r.prop_ad = cur_props.ad[PROP_OUT_W-1:0];
        r.prop_al = cur_props.al[PROP_OUT_W-1:0];
        r.prop_ld = cur_props.ld[PROP_OUT_W-1:0];
        r.prop_aa = cur_props.aa[PROP_OUT_W-1:0];
        r.prop_dd = cur_props.dd[PROP_OUT_W-1:0];
        r.prop_ll = cur_props.ll[PROP_OUT_W-1:0];
        return r;
    endfunction

    function automatic string describe(input result_item_t r);
        return {$sformatf("A=%0d L=%0d D=%0d fired=%0d", r.count_a, r.count_l, r.count_d,
                          r.fired),
                $sformatf(" ad=%0d al=%0d ld=%0d aa=%0d dd=%0d ll=%0d", r.prop_ad, r.prop_al,
                          r.prop_ld, r.prop_aa, r.prop_dd, r.prop_ll)};
    endfunction

    task automatic check_result(input result_item_t got);
        result_item_t want;
        if (expected_results.size() == 0)
        begin
            failures++;
            if (failures <= MAX_REPORTS)
                $display("ERROR: result with nothing outstanding: %s", describe(got));
        end
        else
        begin
            want = expected_results.pop_front();
            n_checked++;
            if (got.count_a !== want.count_a || got.count_l !== want.count_l ||
                got.count_d !== want.count_d || got.fired !== want.fired ||
                got.prop_ad !== want.prop_ad || got.prop_al !== want.prop_al ||
                got.prop_ld !== want.prop_ld || got.prop_aa !== want.prop_aa ||
                got.prop_dd !== want.prop_dd || got.prop_ll !== want.prop_ll)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                begin
                    $display("ERROR: result %0d differs", n_checked);
                    $display("  expected %s", describe(want));
                    $display("  actual   %s", describe(got));
                end
            end
        end
    endtask

    // One command transfer; valid stays high from one command to the next when there is no gap.
    task automatic send_command(input logic cmd, input logic [DRAW_W-1:0] draw);
        int gap;
        step_item_t it;
        result_item_t r;
        it.cmd = cmd;
        it.rand_draw = draw;
        gap = $urandom_range(0, send_idle);
        if (gap > 0)
        begin
            @(negedge clk);
            step_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        step_valid <= 1'b1;
        step_item <= it;
        do
            @(posedge clk);
        while (!step_ready);
        r = advance_system(it);
        expected_results.push_back(r);
        n_commands++;
        if (cmd == CMD_RESTART)
            n_restarts++;
        else
            fire_tally[r.fired]++;
    endtask

    task automatic drain_results();
        @(negedge clk);
        step_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_START_A: start_a = val;
            CFG_START_L: start_l = val;
            CFG_START_D: start_d = val;
            default: ;
        endcase
        n_cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_start_counts(input logic [CW-1:0] a, input logic [CW-1:0] l,
                                     input logic [CW-1:0] d);
        drain_results();
        write_reg(CFG_START_A, a);
        write_reg(CFG_START_L, l);
        write_reg(CFG_START_D, d);
    endtask

    task automatic test_reset_state();
        send_command(CMD_STEP, '0);
        send_command(CMD_STEP, DRAW_MAX);
        send_command(CMD_RESTART, DRAW_MAX);
    endtask

    task automatic test_extreme_counts();
        load_start_counts(COUNT_MAX, COUNT_MAX, COUNT_MAX);
        send_command(CMD_RESTART, '0);
        send_command(CMD_STEP, DRAW_MAX);
        send_command(CMD_STEP, '0);
    endtask

    task automatic test_overflow_guards();
        load_start_counts(CW'(1), CW'(0), COUNT_MAX);
        send_command(CMD_RESTART, random_draw());
        send_command(CMD_STEP, '0);
        load_start_counts(CW'(1), COUNT_MAX, CW'(0));
        send_command(CMD_RESTART, random_draw());
        send_command(CMD_STEP, '0);
        load_start_counts(COUNT_MAX - CW'(1), CW'(1), CW'(1));
        send_command(CMD_RESTART, random_draw());
        send_command(CMD_STEP, draw_at(2, 0));
        // Two below the top, D+L lands exactly on the largest count.
        load_start_counts(COUNT_MAX - CW'(2), CW'(1), CW'(1));
        send_command(CMD_RESTART, random_draw());
        send_command(CMD_STEP, draw_at(2, 0));
    endtask

    task automatic test_selection_boundaries();
        load_start_counts(CW'(3), CW'(2), CW'(4));
        send_command(CMD_RESTART, '0);
        send_command(CMD_STEP, draw_at(1, 1));
        send_command(CMD_STEP, draw_at(1, 0));
        send_command(CMD_STEP, draw_at(2, 1));
        send_command(CMD_STEP, draw_at(2, 0));
        send_command(CMD_STEP, draw_at(3, 1));
        send_command(CMD_STEP, draw_at(3, 0));
        send_command(CMD_STEP, DRAW_MAX);
    endtask

    task automatic test_empty_reactants();
        load_start_counts(CW'(0), CW'(5), CW'(5));
        send_command(CMD_RESTART, random_draw());
        send_command(CMD_STEP, '0);
        // Only A present: the reactive total is zero, every draw is a null event.
        load_start_counts(CW'(7), CW'(0), CW'(0));
        send_command(CMD_RESTART, random_draw());
        send_command(CMD_STEP, '0);
    endtask

    task automatic test_unused_index();
        drain_results();
        write_reg(CFG_UNUSED, {CFG_W{1'b1}});
        send_command(CMD_RESTART, random_draw());
    endtask

    task automatic test_random_runs();
        int phase;
        int i;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase % 3)
                0:
                begin
                    send_idle = IDLE_MAX;
                    sink_idle = IDLE_MAX;
                end
                1:
                begin
                    send_idle = 0;
                    sink_idle = 0;
                end
                default:
                begin
                    // Fast sender against a slow receiver keeps the skid path busy.
                    send_idle = 0;
                    sink_idle = IDLE_MAX;
                end
            endcase
            load_start_counts(pick_count(), pick_count(), pick_count());
            send_command(CMD_RESTART, random_draw());
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                if ($urandom_range(0, 29) == 0)
                    send_command(CMD_RESTART, random_draw());
                else
                    send_command(CMD_STEP, pick_draw());
            end
        end
    endtask

    initial
    begin : result_sink
        int stall;
        result_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = $urandom_range(0, sink_idle);
            if (stall > 0)
            begin
                @(negedge clk);
                result_ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            result_ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_valid);
            check_result(result_item);
        end
    end

    initial
    begin : stimulus
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_START_A;
        cfg_data = '0;
        step_valid = 1'b0;
        step_item = '0;
        start_a = '0;
        start_l = '0;
        start_d = '0;
        cur_a = '0;
        cur_l = '0;
        cur_d = '0;
        cur_props = '0;
        foreach (fire_tally[k])
            fire_tally[k] = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_extreme_counts();
        test_overflow_guards();
        test_selection_boundaries();
        test_empty_reactants();
        test_unused_index();
        test_random_runs();

        drain_results();
        repeat (8) @(posedge clk);
        if (expected_results.size() != 0)
            failures += expected_results.size();

        $display("Run covered %0d commands (%0d restarts), %0d checked results, %0d writes.",
                 n_commands, n_restarts, n_checked, n_cfg_writes);
        $display("Steps fired A+D %0d, A+L %0d, D+L %0d times; %0d null steps; %0d failures.",
                 fire_tally[FIRE_AD], fire_tally[FIRE_AL], fire_tally[FIRE_LD],
                 fire_tally[FIRE_NONE], failures);
        if (failures == 0)
            $display("three_species_ssa_step_core verification clean");
        else
            $display("three_species_ssa_step_core verification failed");
        $finish;
    end

endmodule
